[sv/bitmap_block_allocator_core_assert.svh]
// Assertion macros used by the bitmap allocator controller.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define BBA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle check failed.");

// The antecedent implies the consequent in the next cycle.
`define BBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle check failed.");

`endif

[sv/bba_pkg.sv]
package bba_pkg;

   // Bitmap geometry.
   localparam int BITMAP_BITS = 65536;
   localparam int WORD_BITS   = 32;
   localparam int STORE_WORDS = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W      = $clog2(STORE_WORDS);
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int POS_W       = 16;
   localparam int CNT_W       = 17;

   // Operation codes.
   localparam logic [1:0] OP_CHECK = 2'd0;
   localparam logic [1:0] OP_SET   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_FIND  = 2'd3;

   // Status codes.
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_INVALID   = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [1:0]       op;
      logic [POS_W-1:0] position;
      logic [CNT_W-1:0] count;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             bit_value;
      logic [POS_W-1:0] run_start;
      logic [CNT_W-1:0] run_length;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic clr;
      logic load;
      logic wr;
      logic scan;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic       req_bad;
      logic [1:0] op;
      logic       clr_last;
      logic       wr_last;
      logic       scan_stop;
      logic       scan_wrap;
   } dp_status_type;

endpackage

[sv/bba_ram.sv]
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/bba_datapath.sv]
module bba_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [16:0]           csr_data,
   input  bba_pkg::req_type      req_data,
   input  bba_pkg::ctrl_cmd_type cmd,
   output bba_pkg::dp_status_type stat,
   output bba_pkg::rsp_type      rsp_data
);
   import bba_pkg::*;

   logic [CNT_W-1:0]     bits_in_use_ff, bits_in_use_in;
   logic [CNT_W-1:0]     lim_c;
   logic [CNT_W-1:0]     pos_ext;
   logic [CNT_W:0]       pos_sum;
   logic                 req_bad_c;
   logic [1:0]           op_ff, op_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [CNT_W-1:0]     end_ff, end_in;
   logic [CNT_W-1:0]     lim_ff, lim_in;
   logic [CNT_W-1:0]     cur_ff, cur_in;
   logic [WORD_BITS-1:0] wbuf_ff, wbuf_in;
   logic [CNT_W-1:0]     run_ff, run_in;
   logic [POS_W-1:0]     first_ff, first_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   rsp_type              res_ff, res_in;
   logic [WORD_BITS-1:0] rd_word;
   logic [WORD_BITS-1:0] mask_c;
   logic [WORD_BITS-1:0] new_word;
   logic [CNT_W-1:0]     base_next;
   logic [CNT_W-1:0]     run_inc;
   logic                 cur_bit;
   logic                 off_end;
   logic                 ram_we;
   logic [ADDR_W-1:0]    ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;

   // Effective limit and request validation.
   always_comb begin
      lim_c   = (bits_in_use_ff > CNT_W'(BITMAP_BITS)) ? CNT_W'(BITMAP_BITS) : bits_in_use_ff;
      pos_ext = {1'b0, req_data.position};
      pos_sum = {1'b0, pos_ext} + {1'b0, req_data.count};
      case (req_data.op)
         OP_CHECK: req_bad_c = !(pos_ext < lim_c);
         OP_SET, OP_CLEAR:
            req_bad_c = (req_data.count == '0) || (pos_sum > {1'b0, lim_c});
         default: req_bad_c = (req_data.count == '0) || !(pos_ext < lim_c);
      endcase
   end

   // Word-level mask of the run bits that fall in the buffered word.
   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         mask_c[b] = (BIT_W'(b) >= cur_ff[BIT_W-1:0]) &&
                     ({cur_ff[CNT_W-1:BIT_W], BIT_W'(b)} < end_ff);
      end
      new_word  = (op_ff == OP_SET) ? (wbuf_ff | mask_c) : (wbuf_ff & ~mask_c);
      base_next = {cur_ff[CNT_W-1:BIT_W], {BIT_W{1'b0}}} + CNT_W'(WORD_BITS);
   end

   // Bit-serial free-run search over the buffered word.
   always_comb begin
      cur_bit = wbuf_ff[cur_ff[BIT_W-1:0]];
      off_end = cur_ff >= lim_ff;
      run_inc = run_ff + CNT_W'(1);
   end

   // Status toward the controller.
   always_comb begin
      stat.req_bad   = req_bad_c;
      stat.op        = op_ff;
      stat.clr_last  = (clr_ff == {ADDR_W{1'b1}});
      stat.wr_last   = base_next >= end_ff;
      stat.scan_stop = off_end || (!cur_bit && (run_inc == cnt_ff)) ||
                       (cur_bit && (run_ff != '0));
      stat.scan_wrap = (cur_ff[BIT_W-1:0] == {BIT_W{1'b1}});
   end

   // Next-state logic for the working registers and the result.
   always_comb begin
      bits_in_use_in = csr_we ? csr_data : bits_in_use_ff;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      end_in   = end_ff;
      lim_in   = lim_ff;
      cur_in   = cur_ff;
      wbuf_in  = wbuf_ff;
      run_in   = run_ff;
      first_in = first_ff;
      clr_in   = cmd.clr ? clr_ff + ADDR_W'(1) : clr_ff;
      res_in   = res_ff;
      if (cmd.start) begin
         op_in    = req_data.op;
         cnt_in   = req_data.count;
         end_in   = pos_sum[CNT_W-1:0];
         lim_in   = lim_c;
         cur_in   = pos_ext;
         run_in   = '0;
         first_in = '0;
         res_in   = '{status: ST_INVALID, bit_value: 1'b0, run_start: '0, run_length: '0};
      end
      if (cmd.load) begin
         wbuf_in = rd_word;
         if (op_ff == OP_CHECK) begin
            res_in.status    = ST_OK;
            res_in.bit_value = rd_word[cur_ff[BIT_W-1:0]];
         end
      end
      if (cmd.wr) begin
         cur_in = base_next;
         if (stat.wr_last) begin
            res_in.status     = ST_OK;
            res_in.run_length = cnt_ff;
         end
      end
      if (cmd.scan) begin
         cur_in = cur_ff + CNT_W'(1);
         if (!cur_bit) begin
            run_in = run_inc;
            if (run_ff == '0) begin
               first_in = cur_ff[POS_W-1:0];
            end
         end
         if (off_end) begin
            res_in.status = ST_NOT_FOUND;
         end else if (!cur_bit && (run_inc == cnt_ff)) begin
            res_in.status     = ST_OK;
            res_in.run_start  = (run_ff == '0) ? cur_ff[POS_W-1:0] : first_ff;
            res_in.run_length = run_inc;
         end else if (cur_bit && (run_ff != '0)) begin
            res_in.status     = ST_OK;
            res_in.run_start  = first_ff;
            res_in.run_length = run_ff;
         end
      end
   end

   // Registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         bits_in_use_ff <= CNT_W'(BITMAP_BITS);
         clr_ff         <= '0;
      end else begin
         bits_in_use_ff <= bits_in_use_in;
         clr_ff         <= clr_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      cnt_ff   <= cnt_in;
      end_ff   <= end_in;
      lim_ff   <= lim_in;
      cur_ff   <= cur_in;
      wbuf_ff  <= wbuf_in;
      run_ff   <= run_in;
      first_ff <= first_in;
      res_ff   <= res_in;
   end

   // Bitmap store: clearing pass after reset, then word writes.
   always_comb begin
      ram_we    = cmd.clr || cmd.wr;
      ram_waddr = cmd.clr ? clr_ff : cur_ff[BIT_W+ADDR_W-1:BIT_W];
      ram_wdata = cmd.clr ? '0 : new_word;
   end

   bba_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(STORE_WORDS)
   ) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(cur_ff[BIT_W+ADDR_W-1:BIT_W]),
      .rd_data(rd_word)
   );

   assign rsp_data = res_ff;

endmodule

[sv/bba_ctrl.sv]
module bba_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  bba_pkg::dp_status_type stat,
   output bba_pkg::ctrl_cmd_type  cmd
);
   import bba_pkg::*;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_LOAD  = 7'b0001000,
      S_WRITE = 7'b0010000,
      S_SCAN  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Sequencer for the clearing pass and each request.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = stat.req_bad ? S_DONE : S_READ;
            end
         end
         S_READ: state_in = S_LOAD;
         S_LOAD: begin
            cmd.load = 1'b1;
            case (stat.op)
               OP_CHECK: state_in = S_DONE;
               OP_FIND:  state_in = S_SCAN;
               default:  state_in = S_WRITE;
            endcase
         end
         S_WRITE: begin
            cmd.wr   = 1'b1;
            state_in = stat.wr_last ? S_DONE : S_READ;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_stop)      state_in = S_DONE;
            else if (stat.scan_wrap) state_in = S_READ;
         end
         S_DONE: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   `include "bitmap_block_allocator_core_assert.svh"

   `BBA_ASSERT_SAME(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `BBA_ASSERT_SAME(a_one_write, clock, reset, cmd.wr, !cmd.clr && !cmd.scan)
   `BBA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `BBA_ASSERT_NEXT(a_read_then_load, clock, reset, state_ff == S_READ, cmd.load)

endmodule

[sv/bitmap_block_allocator_core.sv]
// Bitmap block allocator: one bit per block, a set bit marks a used block.
// Request channel (req_valid/req_ready/req_data) takes one beat per request:
// check a bit, set a run, clear a run, or find a free run. Response channel
// (rsp_valid/rsp_ready/rsp_data) returns exactly one beat per request.
// csr_we/csr_data write the searchable bit count; write it only when idle.
// After reset the store is swept to zero, one word a cycle through all 2048
// words, with req_ready low until the sweep ends.
// An invalid request answers in the cycle after acceptance. A check passes
// through the read and load states; a set or clear through read, load and
// write for each 32-bit word touched. A find reads and loads a word, then tests
// one bit a cycle, reading the next word on a wrap. This sequencing comes from
// the single registered read port of the bitmap RAM and the bit-serial scan.
// One request is in flight at a time; req_ready rises in the cycle after the
// response beat leaves. The response beat holds while rsp_ready is low.
module bitmap_block_allocator_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [16:0]      csr_data,
   input  logic             req_valid,
   output logic             req_ready,
   input  bba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bba_pkg::rsp_type rsp_data
);
   import bba_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   // Controller sequences each request.
   bba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   // Datapath holds the store, the cursor and the result.
   bba_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .csr_we  (csr_we),
      .csr_data(csr_data),
      .req_data(req_data),
      .cmd     (cmd),
      .stat    (stat),
      .rsp_data(rsp_data)
   );

endmodule

[tb/sv/bitmap_block_allocator_core_tb.sv]
module bitmap_block_allocator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bba_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_we = 1'b0;
   logic [16:0]      csr_data = '0;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_type          req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_type          rsp_data;

   bitmap_block_allocator_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Clock with a 2 ns period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the bitmap and of the searchable bit count.
   bit          shadow_map [0:BITMAP_BITS-1];
   int unsigned shadow_bits = 65536;

   rsp_type     pending_rsp [$];
   int          fail_count = 0;
   int          req_beats = 0;
   int          rsp_beats = 0;
   bit          calm = 1'b0;

   // Directed rows: an expected beat is typed in only where has_exp is set.
   typedef struct {
      logic [1:0]  op;
      int unsigned pos;
      int unsigned cnt;
      bit          has_exp;
      rsp_type     exp_rsp;
   } directed_row;

   // Works out the response to one request and applies it to the shadow map.
   function automatic rsp_type predict_alloc(req_type rq);
      rsp_type     r;
      int unsigned lim;
      int unsigned pos;
      int unsigned cnt;
      int unsigned p;
      int unsigned run;
      int unsigned first;
      r = '0;
      r.status = ST_INVALID;
      lim = (shadow_bits > BITMAP_BITS) ? BITMAP_BITS : shadow_bits;
      pos = rq.position;
      cnt = rq.count;
      run = 0;
      first = 0;
      case (rq.op)
         OP_CHECK: begin
            if (pos < lim) begin
               r.status = ST_OK;
               r.bit_value = shadow_map[pos];
            end
         end
         OP_SET, OP_CLEAR: begin
            if (cnt != 0 && pos + cnt <= lim) begin
               for (int unsigned i = 0; i < cnt; i++)
                  shadow_map[pos + i] = (rq.op == OP_SET);
               r.status = ST_OK;
               r.run_length = cnt[CNT_W-1:0];
            end
         end
         default: begin
            if (cnt != 0 && pos < lim) begin
               r.status = ST_NOT_FOUND;
               for (p = pos; p < lim; p++) begin
                  if (!shadow_map[p]) begin
                     if (run == 0) first = p;
                     run++;
                     if (run == cnt) break;
                  end else if (run != 0) begin
                     break;
                  end
               end
               if (p < lim && run != 0) begin
                  r.status = ST_OK;
                  r.run_start = first[POS_W-1:0];
                  r.run_length = run[CNT_W-1:0];
               end
            end
         end
      endcase
      return r;
   endfunction

   // Request beats feed the predictor; a typed expectation overrides it.
   bit      typed_next = 1'b0;
   rsp_type typed_rsp;
   always @(posedge clock) begin
      rsp_type r;
      if (!reset && req_valid && req_ready) begin
         r = predict_alloc(req_data);
         if (typed_next) r = typed_rsp;
         pending_rsp.push_back(r);
         req_beats++;
      end
   end

   // Response beats are compared with the oldest expectation.
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_beats++;
         if (pending_rsp.size() == 0) begin
            $error("response beat with no request waiting");
            fail_count++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.bit_value !== e.bit_value) begin
               $error("bit_value expected %0d actual %0d", e.bit_value, rsp_data.bit_value);
               fail_count++;
            end
            if (rsp_data.run_start !== e.run_start) begin
               $error("run_start expected %0d actual %0d", e.run_start, rsp_data.run_start);
               fail_count++;
            end
            if (rsp_data.run_length !== e.run_length) begin
               $error("run_length expected %0d actual %0d",
                      e.run_length, rsp_data.run_length);
               fail_count++;
            end
         end
      end
   end

   // Receiver stalls in random bursts, none in the calm tail.
   int stall_left = 0;
   always @(posedge clock) begin
      if (calm) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Drives one request beat, with an optional gap ahead of it.
   task automatic send_req(logic [1:0] op, int unsigned pos, int unsigned cnt,
                           bit has_exp, rsp_type exp_rsp);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data.op <= op;
      req_data.position <= pos[POS_W-1:0];
      req_data.count <= cnt[CNT_W-1:0];
      typed_next <= has_exp;
      typed_rsp <= exp_rsp;
      do @(posedge clock); while (!req_ready);
   endtask

   // Lowers valid and waits until every response has come back.
   task automatic drain;
      req_valid <= 1'b0;
      typed_next <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_bits_in_use(logic [16:0] v);
      csr_we <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      shadow_bits = v;
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Random request, mostly well formed within the current limit.
   task automatic send_random;
      int unsigned lim;
      int unsigned pos;
      int unsigned cnt;
      int unsigned room;
      logic [1:0]  op;
      rsp_type     none;
      none = '0;
      lim = (shadow_bits > BITMAP_BITS) ? BITMAP_BITS : shadow_bits;
      op = 2'($urandom_range(0, 3));
      if (lim == 0 || $urandom_range(0, 9) < 2) begin
         pos = $urandom_range(0, 65535);
         cnt = $urandom_range(0, 131071);
         // Keep long searches bounded on a wide map.
         if (op == OP_FIND && lim > 4096) cnt = $urandom_range(0, 40);
      end else begin
         pos = $urandom_range(0, lim - 1);
         room = lim - pos;
         if ($urandom_range(0, 9) == 0 && lim <= 4096)
            cnt = $urandom_range(1, room);
         else
            cnt = $urandom_range(1, (room < 48) ? room : 48);
         if (op == OP_FIND && $urandom_range(0, 7) == 0) cnt = $urandom_range(1, 131071);
         if (op == OP_FIND && lim > 4096 && cnt > 64) cnt = 64;
      end
      send_req(op, pos, cnt, 1'b0, none);
   endtask

   // Main sequence: reset, directed rows, then random phases.
   initial begin
      directed_row rows [$];
      directed_row d;
      rsp_type     ok0;
      int unsigned phase_bits [$];
      int          phase_items [$];
      ok0 = '0;
      ok0.status = ST_OK;
      foreach (shadow_map[i]) shadow_map[i] = 1'b0;

      rows.push_back('{OP_CHECK, 0, 0, 1, ok0});
      rows.push_back('{OP_CHECK, 65535, 0, 1, ok0});
      rows.push_back('{OP_SET, 0, 0, 1, '{ST_INVALID, 1'b0, 16'd0, 17'd0}});
      rows.push_back('{OP_CLEAR, 65535, 2, 1, '{ST_INVALID, 1'b0, 16'd0, 17'd0}});
      rows.push_back('{OP_FIND, 0, 0, 1, '{ST_INVALID, 1'b0, 16'd0, 17'd0}});
      rows.push_back('{OP_SET, 0, 8, 1, '{ST_OK, 1'b0, 16'd0, 17'd8}});
      rows.push_back('{OP_CHECK, 7, 0, 1, '{ST_OK, 1'b1, 16'd0, 17'd0}});
      rows.push_back('{OP_FIND, 0, 4, 1, '{ST_OK, 1'b0, 16'd8, 17'd4}});
      rows.push_back('{OP_CLEAR, 2, 2, 1, '{ST_OK, 1'b0, 16'd0, 17'd2}});
      rows.push_back('{OP_FIND, 0, 5, 0, ok0});
      rows.push_back('{OP_FIND, 65530, 65536, 1, '{ST_NOT_FOUND, 1'b0, 16'd0, 17'd0}});
      rows.push_back('{OP_SET, 65535, 1, 1, '{ST_OK, 1'b0, 16'd0, 17'd1}});
      rows.push_back('{OP_FIND, 65535, 1, 1, '{ST_NOT_FOUND, 1'b0, 16'd0, 17'd0}});
      rows.push_back('{OP_CHECK, 65535, 0, 1, '{ST_OK, 1'b1, 16'd0, 17'd0}});
      rows.push_back('{OP_SET, 0, 65536, 1, '{ST_OK, 1'b0, 16'd0, 17'd65536}});
      rows.push_back('{OP_CHECK, 40000, 0, 0, ok0});
      rows.push_back('{OP_FIND, 100, 3, 0, ok0});
      rows.push_back('{OP_CLEAR, 0, 65536, 1, '{ST_OK, 1'b0, 16'd0, 17'd65536}});
      rows.push_back('{OP_SET, 100, 30, 0, ok0});
      rows.push_back('{OP_FIND, 90, 20, 0, ok0});
      rows.push_back('{OP_CHECK, 0, 131071, 0, ok0});

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i]) begin
         d = rows[i];
         send_req(d.op, d.pos, d.cnt, d.has_exp, d.exp_rsp);
      end
      drain();

      // Register settings per phase, extremes included.
      phase_bits = '{0, 1, 64, 2048, 131071, 300, 65536, 1000, 77, 1500, 512};
      phase_items = '{30, 40, 150, 180, 40, 180, 40, 200, 150, 200, 240};
      foreach (phase_bits[ph]) begin
         write_bits_in_use(phase_bits[ph][16:0]);
         if (ph == phase_bits.size() - 1) calm = 1'b1;
         for (int n = 0; n < phase_items[ph]; n++) begin
            // In every third phase, the sender holds off mid-phase until all responses are back.
            if (n == phase_items[ph] / 2 && ph % 3 == 0) drain();
            send_random();
         end
         drain();
      end

      repeat (50) @(posedge clock);
      $display("Ran %0d request beats and %0d response beats over %0d bit-count settings.",
               req_beats, rsp_beats, phase_bits.size() + 1);
      $display("Covered check, set, clear and find, with invalid and not-found cases.");
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #100000000;
      $display("FAIL");
      $finish;
   end

endmodule
